/* design/kdm_pkg.sv */
package kdm_pkg;

    localparam int KEYS_DEF  = 5;
    localparam int LEVEL_W   = 5;
    localparam int CNT_W     = 8;
    localparam int PULSE_W   = 16;
    localparam int EVT_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0]   THRESHOLD_RST = 8'd10;
    localparam logic [PULSE_W-1:0] LIMIT_RST     = 16'hFFFF;
    localparam logic [PULSE_W-1:0] START_PULSE   = 16'd600;
    localparam logic [PULSE_W-1:0] PULSE_STEP    = 16'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 4'd1;

    localparam logic [EVT_W-1:0] EVT_NONE    = 3'd0;
    localparam logic [EVT_W-1:0] EVT_FORWARD = 3'd1;
    localparam logic [EVT_W-1:0] EVT_DISABLE = 3'd2;
    localparam logic [EVT_W-1:0] EVT_UP      = 3'd3;
    localparam logic [EVT_W-1:0] EVT_DOWN    = 3'd4;
    localparam logic [EVT_W-1:0] EVT_TOGGLE  = 3'd5;

    typedef struct packed {
        logic             advance;
        logic [EVT_W-1:0] code;
    } kdm_ctl_t;

    typedef struct packed {
        logic               enable;
        logic               reverse;
        logic [PULSE_W-1:0] pulse;
    } kdm_drive_t;

endpackage

/* design/kdm_if.sv */
interface kdm_in_if
    import kdm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdm_out_if
    import kdm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVT_W-1:0]   key_event;
    logic               motor_enable;
    logic               motor_reverse;
    logic [PULSE_W-1:0] pulse_width;

    modport source (output valid, output key_event, output motor_enable,
                    output motor_reverse, output pulse_width, input ready);
    modport sink   (input valid, input key_event, input motor_enable,
                    input motor_reverse, input pulse_width, output ready);
endinterface

interface kdm_cfg_if
    import kdm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/kdm_scan.sv */
module kdm_scan
    import kdm_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [LEVEL_W-1:0] levels,
    input  logic [CNT_W-1:0]   threshold,
    output logic [EVT_W-1:0]   code
);

    logic [CNT_W-1:0]        cnt_reg  [KEYS];
    logic [CNT_W-1:0]        cnt_next [KEYS];
    logic [KEYS-1:0]         pressed_reg;
    logic [KEYS-1:0]         pressed_next;
    logic [KEYS+LEVEL_W-1:0] levels_ext;
    logic [KEYS-1:0]         high;
    logic [KEYS-1:0]         fire;
    logic [KEYS-1:0]         blocked;
    logic [CNT_W-1:0]        cnt_inc  [KEYS];

    assign levels_ext = (KEYS+LEVEL_W)'(levels);
    assign high       = levels_ext[KEYS-1:0];

    always_comb
    begin
        for (int i = 0; i < KEYS; i++)
        begin
            cnt_inc[i] = (cnt_reg[i] < threshold) ? cnt_reg[i] + CNT_W'(1) : cnt_reg[i];
            fire[i]    = high[i] && (cnt_inc[i] >= threshold) && !pressed_reg[i];
        end
        blocked[0] = 1'b0;
        for (int i = 1; i < KEYS; i++)
        begin
            blocked[i] = blocked[i-1] | fire[i-1];
        end
        code = EVT_NONE;
        for (int i = KEYS - 1; i >= 0; i--)
        begin
            if (fire[i])
            begin
                code = EVT_W'(i + 1);
            end
        end
        for (int i = 0; i < KEYS; i++)
        begin
            cnt_next[i]     = cnt_reg[i];
            pressed_next[i] = pressed_reg[i];
            if (!blocked[i])
            begin
                if (high[i])
                begin
                    cnt_next[i]     = cnt_inc[i];
                    pressed_next[i] = pressed_reg[i] | fire[i];
                end
                else
                begin
                    cnt_next[i]     = '0;
                    pressed_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEYS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            pressed_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < KEYS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            pressed_reg <= pressed_next;
        end
    end

endmodule

/* design/kdm_drive.sv */
module kdm_drive
    import kdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  kdm_ctl_t           ctl,
    input  logic [PULSE_W-1:0] limit,
    output kdm_drive_t         drive_next
);

    kdm_drive_t       drive_reg;
    logic [PULSE_W:0] sum;

    assign sum = {1'b0, drive_reg.pulse} + {1'b0, PULSE_STEP};

    always_comb
    begin
        drive_next = drive_reg;
        case (ctl.code)
            EVT_FORWARD:
            begin
                drive_next.reverse = 1'b0;
                drive_next.enable  = 1'b1;
                drive_next.pulse   = (START_PULSE > limit) ? limit : START_PULSE;
            end
            EVT_DISABLE:
            begin
                drive_next.enable = 1'b0;
            end
            EVT_UP:
            begin
                drive_next.pulse = (sum > {1'b0, limit}) ? limit : sum[PULSE_W-1:0];
            end
            EVT_DOWN:
            begin
                drive_next.pulse = (drive_reg.pulse < PULSE_STEP) ? '0
                                 : drive_reg.pulse - PULSE_STEP;
            end
            EVT_TOGGLE:
            begin
                drive_next.reverse = ~drive_reg.reverse;
            end
            default:
            begin
                drive_next = drive_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
        end
        else if (ctl.advance)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

/* design/key_debounce_motor_command.sv */
// Key debounce and motor command.
// key_in carries one item per scan tick: the raw levels of the keys, bit i
// for key i+1. cmd_out returns exactly one item for each: the press event
// (0 none, k for key k) and the motor enable, direction and pulse value as
// they stand after that tick. cfg writes debounce_threshold (index 0) and
// pulse_limit (index 1); it is always ready. It must be written only while
// idle; the block itself does not enforce this. An accepted item passes
// through the input register and then the result register to cmd_out.
// Throughput: one item per cycle while cmd_out is not stalled; the debounce
// counters and the drive state update in the same cycle the result register
// loads, so the next item sees them at once.
// A stalled cmd_out holds its item; key_in stays ready while the input
// register is empty or moving forward, so at most one more item is taken
// during a stall.
// Reset clears counters, pressed marks, drive state (disabled, forward,
// pulse 0) and loads threshold 10 and limit 65535.
module key_debounce_motor_command
    import kdm_pkg::*;
#(
    parameter int KEYS = KEYS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    kdm_in_if.sink       key_in,
    kdm_out_if.source    cmd_out,
    kdm_cfg_if.sink      cfg
);

    logic [CNT_W-1:0]   threshold_reg;
    logic [PULSE_W-1:0] limit_reg;
    logic               in_vld_reg;
    logic               in_vld_next;
    logic [LEVEL_W-1:0] levels_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [EVT_W-1:0]   event_reg;
    kdm_drive_t         drive_out_reg;
    logic               advance;
    logic               in_take;
    logic [EVT_W-1:0]   code;
    kdm_ctl_t           ctl;
    kdm_drive_t         drive_next;

    assign advance      = in_vld_reg && (!out_vld_reg || cmd_out.ready);
    assign key_in.ready = !in_vld_reg || advance;
    assign in_take      = key_in.valid && key_in.ready;
    assign cfg.ready    = 1'b1;

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (cmd_out.ready ? 1'b0 : out_vld_reg);

    assign ctl.advance = advance;
    assign ctl.code    = code;

    kdm_scan #(
        .KEYS (KEYS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .levels    (levels_reg),
        .threshold (threshold_reg),
        .code      (code)
    );

    kdm_drive u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .limit      (limit_reg),
        .drive_next (drive_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            limit_reg     <= LIMIT_RST;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.index == CFG_THRESHOLD)
            begin
                threshold_reg <= cfg.data[CNT_W-1:0];
            end
            if (cfg.valid && cfg.index == CFG_LIMIT)
            begin
                limit_reg <= cfg.data[PULSE_W-1:0];
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            levels_reg <= key_in.key_levels;
        end
        if (advance)
        begin
            event_reg     <= code;
            drive_out_reg <= drive_next;
        end
    end

    assign cmd_out.valid         = out_vld_reg;
    assign cmd_out.key_event     = event_reg;
    assign cmd_out.motor_enable  = drive_out_reg.enable;
    assign cmd_out.motor_reverse = drive_out_reg.reverse;
    assign cmd_out.pulse_width   = drive_out_reg.pulse;

endmodule

/* design/kdm_checker.sv */
module kdm_checker
    import kdm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [EVT_W-1:0]   key_event,
    input logic               motor_enable,
    input logic               motor_reverse,
    input logic [PULSE_W-1:0] pulse_width
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_event)
            && $stable(pulse_width) && $stable(motor_enable))
        else $error("result item changed while stalled");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_event <= EVT_TOGGLE)
        else $error("event code out of range");

    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event == EVT_FORWARD |-> motor_enable && !motor_reverse)
        else $error("forward press did not enable forward drive");

    a_disable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_event == EVT_DISABLE |-> !motor_enable)
        else $error("disable press left drive enabled");

endmodule

bind key_debounce_motor_command kdm_checker u_kdm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (cmd_out.valid),
    .out_ready     (cmd_out.ready),
    .key_event     (cmd_out.key_event),
    .motor_enable  (cmd_out.motor_enable),
    .motor_reverse (cmd_out.motor_reverse),
    .pulse_width   (cmd_out.pulse_width)
);
